>>> rtl/bitmap_slab_allocator_macros.svh
// assertion macros for the bitmap slab allocator checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef BITMAP_SLAB_ALLOCATOR_MACROS_SVH
`define BITMAP_SLAB_ALLOCATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BSA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bitmap slab allocator: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bitmap slab allocator: next-cycle check failed");

`endif

>>> rtl/bsa_pkg.sv
// shared types and codes of the bitmap slab allocator
// no dependencies
`default_nettype none

package bsa_pkg;

    localparam int ADDR_W    = 48;
    localparam int LINES_W   = 19;
    localparam int CNT_REG_W = 9;
    localparam int STATUS_W  = 3;
    localparam int BIDX_W    = 8;

    // command codes
    localparam logic [1:0] CMD_ALLOC    = 2'd0;
    localparam logic [1:0] CMD_RELEASE  = 2'd1;
    localparam logic [1:0] CMD_FREE_ALL = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_BASE_ADDRESS     = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE_LINES = 2'd1;
    localparam logic [1:0] REG_BLOCK_COUNT      = 2'd2;
    localparam logic [1:0] REG_DEFENSIVE_CHECKS = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] address;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   block_address;
        logic [BIDX_W-1:0]   block_index;
    } t_out_item;

endpackage

`default_nettype wire

>>> rtl/bsa_map.sv
// used-bit memory of the allocator, one row of block bits per address
// single address for read and write, registered read data; no package use
`default_nettype none

module bsa_map #(
    parameter int WORDS   = 4,
    parameter int WIDTH   = 64,
    parameter int ADDR_BITS = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    output logic      [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [WORDS];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/bsa_div.sv
// restoring divider, one quotient bit per cycle, for address-to-index mapping
// uses bsa_pkg for the address width
`default_nettype none

module bsa_div #(
    parameter int DEN_W = 26
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [bsa_pkg::ADDR_W-1:0] i_dividend,
    input  wire logic [DEN_W-1:0]          i_divisor,
    output logic                           o_done,
    output logic      [bsa_pkg::ADDR_W-1:0] o_quot,
    output logic      [DEN_W-1:0]          o_rem
);
    import bsa_pkg::*;

    localparam int STEP_W = $clog2(ADDR_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [ADDR_W-1:0] r_quot, n_quot;
    logic [DEN_W-1:0]  r_rem,  n_rem;
    logic [DEN_W:0]    trial;
    logic              fits;

    // one shift-subtract step
    always_comb begin
        trial  = {r_rem, r_quot[ADDR_W-1]};
        fits   = (trial >= {1'b0, i_divisor});
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quot = r_quot;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_quot = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quot = {r_quot[ADDR_W-2:0], fits};
            n_rem  = fits ? DEN_W'(trial - {1'b0, i_divisor}) : DEN_W'(trial);
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(ADDR_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> rtl/bsa_ffz.sv
// lowest-set-bit finder over one row of free flags, as a pairwise tree
// no package use
`default_nettype none

module bsa_ffz #(
    parameter int WIDTH = 64
) (
    input  wire logic [WIDTH-1:0]         i_free,
    output logic                          o_found,
    output logic      [$clog2(WIDTH)-1:0] o_pos
);

    localparam int LVLS = $clog2(WIDTH);
    localparam int PAD  = 1 << LVLS;

    logic            any_l [LVLS+1][PAD];
    logic [LVLS-1:0] pos_l [LVLS+1][PAD];

    // each level merges neighbor pairs, preferring the lower one
    always_comb begin
        for (int k = 0; k <= LVLS; k++) begin
            for (int n = 0; n < PAD; n++) begin
                any_l[k][n] = 1'b0;
                pos_l[k][n] = '0;
            end
        end
        for (int n = 0; n < WIDTH; n++) begin
            any_l[0][n] = i_free[n];
        end
        for (int k = 0; k < LVLS; k++) begin
            for (int n = 0; n < (PAD >> (k + 1)); n++) begin
                any_l[k+1][n] = any_l[k][2*n] | any_l[k][2*n+1];
                pos_l[k+1][n] = any_l[k][2*n] ? pos_l[k][2*n]
                                              : (pos_l[k][2*n+1] | LVLS'(1 << k));
            end
        end
    end

    assign o_found = any_l[LVLS][0];
    assign o_pos   = pos_l[LVLS][0];

endmodule

`default_nettype wire

>>> rtl/bitmap_slab_allocator.sv
// top level of the bitmap slab allocator: sequencer, config registers, shared multiplier
// uses bsa_pkg, bsa_map, bsa_div and bsa_ffz
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_in_item  (cmd, address)
//  out      output     o_out_valid / i_out_ready  o_out_item (status, block_address, block_index)
//  cfg      input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// allocate: S_A_RD and S_A_CHK for each bitmap row scanned, then S_A_MUL, S_A_ADDR and S_DONE
// release: S_R_MUL and S_R_RANGE, then the 48-step divider (one quotient bit per cycle), skipped when outside
// free all: one bitmap row cleared per cycle
// after reset a clearing pass over every bitmap row runs before the first input transfer
// one item at a time; a finished result waits in the output register while the next is taken
`default_nettype none

module bitmap_slab_allocator #(
    parameter int MAX_BLOCKS = 256,
    parameter int WORD_BITS  = 64,
    parameter int LINE_BYTES = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire bsa_pkg::t_in_item             i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output bsa_pkg::t_out_item                 o_out_item,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_idx,
    input  wire logic [bsa_pkg::ADDR_W-1:0]    i_cfg_data
);
    import bsa_pkg::*;

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
    localparam int SAT_W     = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
    localparam int SIZE_W    = LINES_W + $clog2(LINE_BYTES + 1);
    localparam int P_W       = SIZE_W + CNT_W;
    localparam int EW        = ((P_W > ADDR_W) ? P_W : ADDR_W) + 1;
    localparam int BI_W      = $clog2(MAP_WORDS * WORD_BITS + 1);
    // reciprocal of the row width, exact for every block index
    localparam int RSH       = IDX_W + BIT_W;
    localparam int RECIP     = ((1 << RSH) + WORD_BITS - 1) / WORD_BITS;
    localparam int SP_W      = IDX_W + RSH + 1;

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_A_RD    = 13'b0000000000100,
        S_A_CHK   = 13'b0000000001000,
        S_A_MUL   = 13'b0000000010000,
        S_A_ADDR  = 13'b0000000100000,
        S_R_MUL   = 13'b0000001000000,
        S_R_RANGE = 13'b0000010000000,
        S_R_DIV   = 13'b0000100000000,
        S_R_SPLIT = 13'b0001000000000,
        S_R_RD    = 13'b0010000000000,
        S_R_MOD   = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } t_state;

    // config registers
    logic [ADDR_W-1:0]   r_base;
    logic [SIZE_W-1:0]   r_blk_bytes;
    logic [CNT_W-1:0]    r_count;
    logic                r_checks;

    // sequencer and payload registers
    t_state              r_state, n_state;
    logic [WADDR_W-1:0]  r_word, n_word;
    logic [BI_W-1:0]     r_base_idx, n_base_idx;
    logic                r_clr_reply, n_clr_reply;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0]   r_baddr, n_baddr;
    logic [BIDX_W-1:0]   r_bidx, n_bidx;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [P_W-1:0]      r_prod, n_prod;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    // datapath nets
    logic [LINES_W-1:0]   cfg_lines;
    logic [CNT_REG_W-1:0] cfg_cnt;
    logic [CNT_W-1:0]     mul_b;
    logic [P_W-1:0]       mul_res;
    logic [EW-1:0]        end_sum;
    logic                 outside;
    logic [SP_W-1:0]      split_prod;
    logic [WORD_BITS-1:0] map_rdata, map_wdata, free_vec, bit_oh;
    logic                 map_we;
    logic                 ffz_found;
    logic [BIT_W-1:0]     ffz_pos;
    logic                 div_start, div_done;
    logic [ADDR_W-1:0]    div_quot;
    logic [SIZE_W-1:0]    div_rem;
    logic [BI_W:0]        blk_pos;
    logic                 last_word;

    bsa_map #(
        .WORDS     (MAP_WORDS),
        .WIDTH     (WORD_BITS),
        .ADDR_BITS (WADDR_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_addr  (r_word),
        .i_wdata (map_wdata),
        .o_rdata (map_rdata)
    );

    bsa_div #(
        .DEN_W (SIZE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_addr - r_base),
        .i_divisor  (r_blk_bytes),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    bsa_ffz #(
        .WIDTH (WORD_BITS)
    ) u_ffz (
        .i_free  (free_vec),
        .o_found (ffz_found),
        .o_pos   (ffz_pos)
    );

    // shared multiplier: block bytes times block index or block count
    assign mul_b   = (r_state == S_A_MUL) ? CNT_W'(r_idx) : r_count;
    assign mul_res = P_W'(r_blk_bytes) * P_W'(mul_b);

    // region bounds, compared without wrap
    assign end_sum = EW'(r_base) + EW'(r_prod);
    assign outside = (r_addr < r_base) || (EW'(r_addr) >= end_sum);

    // row of a block index by reciprocal multiply
    assign split_prod = SP_W'(r_idx) * SP_W'(RECIP);

    // free flags of the current row, blocks at or past the count masked off
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            blk_pos     = (BI_W + 1)'(r_base_idx) + (BI_W + 1)'(b);
            free_vec[b] = !map_rdata[b] && (blk_pos < (BI_W + 1)'(r_count));
        end
    end

    assign bit_oh    = {{(WORD_BITS - 1){1'b0}}, 1'b1} << r_bit;
    assign last_word = (r_word == WADDR_W'(MAP_WORDS - 1));
    assign cfg_lines = i_cfg_data[LINES_W-1:0];
    assign cfg_cnt   = i_cfg_data[CNT_REG_W-1:0];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_base_idx  = r_base_idx;
        n_clr_reply = r_clr_reply;
        n_addr      = r_addr;
        n_status    = r_status;
        n_baddr     = r_baddr;
        n_bidx      = r_bidx;
        n_idx       = r_idx;
        n_bit       = r_bit;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        map_we      = 1'b0;
        map_wdata   = '0;
        div_start   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // clear one bitmap row per cycle
            S_CLEAR: begin
                map_we = 1'b1;
                if (last_word) begin
                    n_word  = '0;
                    n_state = r_clr_reply ? S_DONE : S_IDLE;
                end else begin
                    n_word = r_word + WADDR_W'(1);
                end
            end
            // take a new item
            S_IDLE: begin
                if (i_in_valid) begin
                    n_addr      = i_in_item.address;
                    n_status    = ST_OK;
                    n_baddr     = '0;
                    n_bidx      = '0;
                    n_word      = '0;
                    n_base_idx  = '0;
                    n_clr_reply = 1'b0;
                    case (i_in_item.cmd)
                        CMD_ALLOC:    n_state = S_A_RD;
                        CMD_RELEASE:  n_state = S_R_MUL;
                        CMD_FREE_ALL: begin
                            n_clr_reply = 1'b1;
                            n_state     = S_CLEAR;
                        end
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            // allocate: read the next row unless past the count
            S_A_RD: begin
                if ((BI_W + 1)'(r_base_idx) >= (BI_W + 1)'(r_count)) begin
                    n_status = ST_NO_FREE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_A_CHK;
                end
            end
            // allocate: pick the lowest free block of the row
            S_A_CHK: begin
                if (ffz_found) begin
                    map_we    = 1'b1;
                    map_wdata = map_rdata | ({{(WORD_BITS - 1){1'b0}}, 1'b1} << ffz_pos);
                    n_idx     = IDX_W'(r_base_idx + BI_W'(ffz_pos));
                    n_bidx    = BIDX_W'(r_base_idx + BI_W'(ffz_pos));
                    n_state   = S_A_MUL;
                end else if (last_word) begin
                    n_status = ST_NO_FREE;
                    n_state  = S_DONE;
                end else begin
                    n_word     = r_word + WADDR_W'(1);
                    n_base_idx = r_base_idx + BI_W'(WORD_BITS);
                    n_state    = S_A_RD;
                end
            end
            S_A_MUL: begin
                n_prod  = mul_res;
                n_state = S_A_ADDR;
            end
            S_A_ADDR: begin
                n_baddr = ADDR_W'(EW'(r_base) + EW'(r_prod));
                n_state = S_DONE;
            end
            // release: region end, then bounds check and divider start
            S_R_MUL: begin
                n_prod  = mul_res;
                n_state = S_R_RANGE;
            end
            S_R_RANGE: begin
                if (r_checks && outside) begin
                    n_status = ST_OUTSIDE;
                    n_state  = S_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_R_DIV;
                end
            end
            S_R_DIV: begin
                if (div_done) begin
                    if (r_checks) begin
                        if (div_rem != '0) begin
                            n_status = ST_MISALIGNED;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = IDX_W'(div_quot);
                            n_state = S_R_SPLIT;
                        end
                    end else if (div_quot >= ADDR_W'(r_count)) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = IDX_W'(div_quot);
                        n_state = S_R_SPLIT;
                    end
                end
            end
            S_R_SPLIT: begin
                n_word  = WADDR_W'(split_prod >> RSH);
                n_state = S_R_RD;
            end
            S_R_RD: begin
                n_bit   = BIT_W'(r_idx - IDX_W'(r_word * WORD_BITS));
                n_state = S_R_MOD;
            end
            // release: test and clear the block bit
            S_R_MOD: begin
                n_bidx = BIDX_W'(r_idx);
                if (r_checks && !map_rdata[r_bit]) begin
                    n_status = ST_ALREADY_FREE;
                end else begin
                    map_we    = 1'b1;
                    map_wdata = map_rdata & ~bit_oh;
                end
                n_state = S_DONE;
            end
            // hand the result to the output register
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = r_status;
                    n_out.block_address = r_baddr;
                    n_out.block_index   = r_bidx;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_word      <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
            r_base      <= '0;
            r_blk_bytes <= SIZE_W'(LINE_BYTES);
            r_count     <= CNT_W'(1);
            r_checks    <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BASE_ADDRESS: r_base <= i_cfg_data;
                    REG_BLOCK_SIZE_LINES: begin
                        r_blk_bytes <= ((cfg_lines == '0) ? SIZE_W'(1) : SIZE_W'(cfg_lines))
                                       * SIZE_W'(LINE_BYTES);
                    end
                    REG_BLOCK_COUNT: begin
                        r_count <= (SAT_W'(cfg_cnt) > SAT_W'(MAX_BLOCKS)) ?
                                   CNT_W'(MAX_BLOCKS) : CNT_W'(cfg_cnt);
                    end
                    REG_DEFENSIVE_CHECKS: r_checks <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_base_idx <= n_base_idx;
        r_addr     <= n_addr;
        r_status   <= n_status;
        r_baddr    <= n_baddr;
        r_bidx     <= n_bidx;
        r_idx      <= n_idx;
        r_bit      <= n_bit;
        r_prod     <= n_prod;
        r_out      <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

>>> rtl/bsa_chk.sv
// port-level checker of the bitmap slab allocator, bound to the top level
// uses bsa_pkg and bitmap_slab_allocator_macros.svh
`default_nettype none
`include "bitmap_slab_allocator_macros.svh"

module bsa_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire bsa_pkg::t_in_item  i_in_item,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire bsa_pkg::t_out_item o_out_item
);
    import bsa_pkg::*;

    // a result offered stays offered and unchanged until its transfer
    `BSA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `BSA_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_item))

    // one item at a time: busy right after an allocate, release or free-all transfer
    `BSA_ASSERT_NEXT(a_busy_after_transfer, i_in_valid && o_in_ready && (i_in_item.cmd == CMD_ALLOC || i_in_item.cmd == CMD_RELEASE || i_in_item.cmd == CMD_FREE_ALL), !o_in_ready)

    // only a good allocate carries an address
    `BSA_ASSERT_NOW(a_addr_zero_on_error, o_out_valid && o_out_item.status != ST_OK, o_out_item.block_address == '0)

    // rejected release by bounds or alignment reports index zero
    `BSA_ASSERT_NOW(a_index_zero_on_reject, o_out_valid && (o_out_item.status == ST_OUTSIDE || o_out_item.status == ST_MISALIGNED), o_out_item.block_index == '0)

endmodule

bind bitmap_slab_allocator bsa_chk u_bsa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

>>> bench/tb.sv
// testbench for bitmap_slab_allocator: random and directed allocate, release and free-all traffic
// depends on bsa_pkg and the bitmap_slab_allocator top level; self-checking with a scoreboard class
`timescale 1ns / 100ps

module tb;
    import bsa_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [47:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;

    // predicts each result from a private copy of the bitmap and registers
    class alloc_scoreboard;
        logic [255:0] used_bits;
        logic [47:0]  base;
        logic [18:0]  lines;
        logic [8:0]   count;
        logic         checks;
        t_out_item    expected_q[$];
        int           errors;

        function new();
            used_bits = '0;
            base      = '0;
            lines     = 19'd1;
            count     = 9'd1;
            checks    = 1'b1;
            errors    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [47:0] data);
            case (idx)
                REG_BASE_ADDRESS:     base   = data;
                REG_BLOCK_SIZE_LINES: lines  = data[18:0];
                REG_BLOCK_COUNT:      count  = data[8:0];
                REG_DEFENSIVE_CHECKS: checks = data[0];
                default: ;
            endcase
        endfunction

        // zero lines behaves as one line
        function logic [63:0] block_bytes();
            return ((lines == 0) ? 64'd1 : {45'd0, lines}) * 64'd64;
        endfunction

        // count saturates at the bitmap size
        function logic [63:0] live_count();
            return (count > 9'd256) ? 64'd256 : {55'd0, count};
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // apply one accepted request to the bitmap and queue its result
        function void note_request(t_in_item req);
            t_out_item   res;
            logic [63:0] sz;
            logic [63:0] cnt;
            logic [63:0] base64;
            logic [63:0] addr64;
            logic [63:0] top;
            logic [63:0] idx;
            logic [63:0] blk_addr;
            bit          found;
            sz     = block_bytes();
            cnt    = live_count();
            base64 = {16'd0, base};
            addr64 = {16'd0, req.address};
            res    = '0;
            found  = 0;
            case (req.cmd)
                CMD_ALLOC: begin
                    res.status = ST_NO_FREE;
                    for (int i = 0; i < cnt; i++) begin
                        if (!found && !used_bits[i]) begin
                            found        = 1;
                            used_bits[i] = 1'b1;
                            blk_addr     = base64 + 64'(i) * sz;
                            res.status        = ST_OK;
                            res.block_index   = i[7:0];
                            res.block_address = blk_addr[47:0];
                        end
                    end
                end
                CMD_RELEASE: begin
                    if (checks) begin
                        // bounds compared without wrap
                        top = base64 + sz * cnt;
                        if (addr64 < base64 || addr64 >= top) begin
                            res.status = ST_OUTSIDE;
                        end else if (((addr64 - base64) % sz) != 0) begin
                            res.status = ST_MISALIGNED;
                        end else begin
                            idx = (addr64 - base64) / sz;
                            res.block_index = idx[7:0];
                            if (!used_bits[idx[7:0]])
                                res.status = ST_ALREADY_FREE;
                            else
                                used_bits[idx[7:0]] = 1'b0;
                        end
                    end else begin
                        // offset wraps at 48 bits, indexes past the count are ignored
                        idx = ((addr64 - base64) & {16'd0, ADDR_ONES}) / sz;
                        if (idx < cnt) begin
                            used_bits[idx[7:0]] = 1'b0;
                            res.block_index     = idx[7:0];
                        end
                    end
                end
                CMD_FREE_ALL: used_bits = '0;
                default: ;
            endcase
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 50)
                $display("%0t: %s got %0h expected %0h", $time, what, got, want);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(got), 64'd0);
            end else begin
                want = expected_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.block_address !== want.block_address)
                    report_mismatch("block_address", 64'(got.block_address),
                                    64'(want.block_address));
                if (got.block_index !== want.block_index)
                    report_mismatch("block_index", 64'(got.block_index),
                                    64'(want.block_index));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_item;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [47:0] cfg_data;

    alloc_scoreboard sb;
    int burst_left;
    int stall_mode;
    int cycle_cnt;

    bitmap_slab_allocator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("bitmap_slab_allocator: mismatch");
        $finish;
    end

    // receiver stalls, switching between always ready, coin flip and long stalls
    initial begin
        out_ready  = 1'b0;
        stall_mode = 0;
        forever begin
            @(negedge clk);
            if ($urandom_range(299) == 0)
                stall_mode = $urandom_range(2);
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(1) == 1);
                default: out_ready <= ($urandom_range(9) == 0);
            endcase
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_item);
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom_range(16'hFFFF)), $urandom()};
    endfunction

    // one request transfer, then maybe a gap that ends the current burst
    task automatic push_request(input logic [1:0] cmd, input logic [47:0] addr);
        t_in_item req;
        req.cmd     = cmd;
        req.address = addr;
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(req);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(negedge clk);
            burst_left = ($urandom_range(3) == 0) ? 60 : $urandom_range(12, 1);
        end
    endtask

    // hold off until every expected result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // write all four registers on back-to-back cycles, junk above the field width at times
    task automatic write_regs(input logic [47:0] base, input logic [18:0] lines,
                              input logic [8:0] count, input logic checks);
        logic [47:0] vals[4];
        bit          junk;
        junk    = ($urandom_range(1) == 1);
        vals[0] = base;
        vals[1] = junk ? rand48() : '0;
        vals[1][18:0] = lines;
        vals[2] = junk ? rand48() : '0;
        vals[2][8:0] = count;
        vals[3] = junk ? rand48() : '0;
        vals[3][0] = checks;
        for (int i = 0; i < 4; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= 2'(i);
            cfg_data <= vals[i];
            sb.write_reg(2'(i), vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // random traffic under one register setting, mostly aligned releases inside the region
    task automatic run_phase(input int n_items, input int alloc_pct, input bit mid_hold);
        logic [63:0] sz;
        logic [63:0] cnt;
        logic [63:0] k;
        logic [63:0] a;
        int          r;
        int          kind;
        for (int n = 0; n < n_items; n++) begin
            sz  = sb.block_bytes();
            cnt = sb.live_count();
            k   = 64'($urandom_range(32'(cnt)));
            a   = {16'd0, sb.base} + k * sz;
            r   = $urandom_range(99);
            if (mid_hold && n == n_items / 2)
                wait_idle();
            if (r < alloc_pct) begin
                push_request(CMD_ALLOC, rand48());
            end else if (r < 95) begin
                kind = $urandom_range(9);
                if (kind == 6)
                    a = a + 64'($urandom_range(32'(sz - 64'd1), 1));
                else if (kind == 7)
                    a = {16'd0, sb.base} - 64'($urandom_range(4096, 1));
                else if (kind >= 8)
                    a = {16'd0, rand48()};
                push_request(CMD_RELEASE, a[47:0]);
            end else if (r < 98) begin
                push_request(CMD_FREE_ALL, rand48());
            end else begin
                push_request(CMD_UNUSED, rand48());
            end
        end
    endtask

    // stimulus
    initial begin
        logic [47:0] b;
        logic [47:0] rbase;
        logic [18:0] rlines;
        logic [8:0]  rcount;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_we     = 1'b0;
        cfg_idx    = REG_BASE_ADDRESS;
        cfg_data   = '0;
        rst_n      = 1'b0;
        burst_left = 5;
        sb = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: one block of one line at address zero
        push_request(CMD_ALLOC, ADDR_ONES);
        push_request(CMD_ALLOC, 48'd0);
        push_request(CMD_RELEASE, 48'd0);
        push_request(CMD_RELEASE, 48'd0);
        push_request(CMD_RELEASE, 48'd64);
        push_request(CMD_RELEASE, 48'd1);

        // four blocks of two lines, checks on: fill, overflow and each release error
        wait_idle();
        b = 48'h0012_3456_7890;
        write_regs(b, 19'd2, 9'd4, 1'b1);
        repeat (5) push_request(CMD_ALLOC, 48'd0);
        push_request(CMD_RELEASE, b + 48'd128);
        push_request(CMD_RELEASE, b + 48'd128);
        push_request(CMD_RELEASE, b + 48'd130);
        push_request(CMD_RELEASE, b - 48'd16);
        push_request(CMD_RELEASE, b + 48'd512);
        push_request(CMD_RELEASE, ADDR_ONES);
        push_request(CMD_UNUSED, ADDR_ONES);
        push_request(CMD_ALLOC, 48'd0);
        push_request(CMD_FREE_ALL, ADDR_ONES);
        push_request(CMD_ALLOC, 48'd0);

        // checks off: truncated index, index past the count, wrapped offset
        wait_idle();
        write_regs(b, 19'd2, 9'd4, 1'b0);
        push_request(CMD_RELEASE, b + 48'd389);
        push_request(CMD_RELEASE, b + 48'd512);
        push_request(CMD_RELEASE, 48'd0);

        // extremes: zero blocks with zero lines, then top base with largest blocks
        wait_idle();
        write_regs(48'd0, 19'd0, 9'd0, 1'b1);
        run_phase(40, 40, 1'b0);
        wait_idle();
        write_regs(ADDR_ONES, 19'h7FFFF, 9'h1FF, 1'b0);
        run_phase(50, 50, 1'b0);

        // full bitmap near the top of the address space, addresses wrap
        wait_idle();
        write_regs(48'hFFFF_FFFF_F000, 19'd1, 9'd256, 1'b1);
        run_phase(320, 85, 1'b1);

        // random settings
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            case ($urandom_range(3))
                0:       rbase = rand48() & ~48'hF;
                1:       rbase = rand48();
                2:       rbase = 48'd0;
                default: rbase = ADDR_ONES - 48'($urandom_range(1 << 20));
            endcase
            case ($urandom_range(4))
                0:       rlines = 19'd0;
                1:       rlines = 19'd1;
                2:       rlines = 19'($urandom_range(16, 2));
                3:       rlines = 19'($urandom_range(19'h7FFFF, 1));
                default: rlines = 19'd3;
            endcase
            case ($urandom_range(3))
                0:       rcount = 9'($urandom_range(16, 1));
                1:       rcount = 9'($urandom_range(80, 17));
                2:       rcount = ($urandom_range(1) == 1) ? 9'd64 : 9'd129;
                default: rcount = 9'($urandom_range(300, 1));
            endcase
            write_regs(rbase, rlines, rcount, $urandom_range(1) == 1);
            run_phase(50, $urandom_range(65, 35), p == 2);
        end

        // drain and watch for stray results
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        if (sb.errors == 0)
            $display("bitmap_slab_allocator: match");
        else
            $display("bitmap_slab_allocator: mismatch");
        $finish;
    end

endmodule
